/* sv/ray_box_intersect_top_defines.svh */
// Assertion macros shared by the ray box intersection RTL.
`ifndef RAY_BOX_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define RBI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define RBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rbi_pkg.sv */
// Types, constants and helpers for the ray box intersection block.
package rbi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW       = 32;            // coordinate width
  localparam int NAX      = 3;
  localparam int NFACE    = 6;
  localparam int T_FRAC   = 28;            // fraction bits of t
  localparam int NUM_W    = 33;            // |face - origin|
  localparam int DEN_W    = 32;            // |dir|
  localparam int QW       = NUM_W + T_FRAC; // quotient magnitude width
  localparam int QLO_W    = 32;
  localparam int QHI_W    = QW - QLO_W;
  localparam int TW       = QW + 1;        // signed t
  localparam int CAP_BITS = 40;
  localparam int MW       = CAP_BITS + 1;  // capped product magnitude
  localparam int VW       = 43;            // unsaturated coordinate
  localparam int DIV_LAT  = QW;
  localparam int FACE_LAT = 3;
  localparam int SEL_LAT  = 3;
  localparam int IN_W     = 2 * NAX * CW;
  localparam int OUT_W    = 104;
  localparam int OUT_USED = 1 + NAX * CW;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z    = 3'd5;
  localparam logic [IDX_W-1:0] REG_RAY_ONLY = 3'd6;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [VW-1:0] wide_t;

  typedef struct packed {
    logic                    f;
    logic signed [TW-1:0]    t;
    wide_t [NAX-1:0]         v;
  } cand_t;

  function automatic coord_t sat32(input wide_t v);
    coord_t r;
    if (v > VW'(coord_t'({1'b0, {(CW-1){1'b1}}}))) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v < VW'(coord_t'({1'b1, {(CW-1){1'b0}}}))) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/rbi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module rbi_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rbi_pkg::NUM_W-1:0] num_i,
  input  logic [rbi_pkg::DEN_W-1:0] den_i,
  output logic [rbi_pkg::QW-1:0]    q_o
);
  import rbi_pkg::*;

  logic [NUM_W-1:0] num_r [NUM_W-1];
  logic [DEN_W-1:0] den_r [QW-1];
  logic [DEN_W-1:0] rem_r [QW];
  logic [QW-1:0]    q_r   [QW];

  // The dividend is num shifted left by T_FRAC; its low bits are zero.
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QW-1:0]    q_in;
    logic [DEN_W-1:0] den_in;
    logic             nbit;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign den_in = den_i;
      assign nbit   = num_i[NUM_W-1];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign den_in = den_r[i-1];
      if (i < NUM_W) begin : g_nb
        assign nbit = num_r[i-1][NUM_W-1-i];
      end else begin : g_zb
        assign nbit = 1'b0;
      end
    end

    assign sh   = {rem_in, nbit};
    assign diff = sh - {1'b0, den_in};
    assign ge   = (sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        q_r[i]   <= {q_in[QW-2:0], ge};
      end
    end

    if (i < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= den_in;
        end
      end
    end

    if (i < NUM_W - 1) begin : g_num
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[i] <= (i == 0) ? num_i : num_r[i == 0 ? 0 : i-1];
        end
      end
    end
  end

  assign q_o = q_r[QW-1];

endmodule

/* sv/rbi_face.sv */
// One box face: hit point from t, bounds check on the other two axes.
module rbi_face #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF,
  parameter int AX        = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 ray_only_i,
  input  rbi_pkg::coord_t [rbi_pkg::NAX-1:0]   box_lo_i,
  input  rbi_pkg::coord_t [rbi_pkg::NAX-1:0]   box_hi_i,
  input  rbi_pkg::coord_t [rbi_pkg::NAX-1:0]   org_i,
  input  rbi_pkg::coord_t [rbi_pkg::NAX-1:0]   dir_i,
  input  logic [rbi_pkg::QW-1:0]               q_i,
  input  logic                                 tneg_i,
  input  logic                                 skip_i,
  output rbi_pkg::cand_t                       cand_o
);
  import rbi_pkg::*;

  localparam wide_t EPS =
    VW'(((64'sd1 <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000);
  localparam int HI_SH = CAP_BITS - QLO_W + T_FRAC;
  localparam int HI_UP = QLO_W - T_FRAC;
  localparam int PL_W  = 2 * QLO_W;
  localparam int PH_W  = QHI_W + CW;
  localparam logic [MW-1:0] CAP = {1'b1, {CAP_BITS{1'b0}}};

  logic [CW-1:0]        md      [NAX];
  logic [PL_W-1:0]      plo_r   [NAX];
  logic [PH_W-1:0]      phi_r   [NAX];
  logic [MW-1:0]        sum     [NAX];
  logic [MW-1:0]        m_nxt   [NAX];
  logic [MW-1:0]        m_r     [NAX];
  wide_t                v       [NAX];
  logic [NAX-1:0]       sgn_a_r, sgn_b_r;
  coord_t [NAX-1:0]     org_a_r, org_b_r;
  logic [QW-1:0]        q_a_r, q_b_r;
  logic                 tneg_a_r, tneg_b_r;
  logic                 tpos_a_r, tpos_b_r;
  logic                 skip_a_r, skip_b_r;
  logic                 ok;
  cand_t                cand_nxt;
  cand_t                cand_r;

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      md[k] = dir_i[k][CW-1] ? (CW'(0) - CW'(dir_i[k])) : CW'(dir_i[k]);
    end
  end

  // Stage A: partial products of |t| and |dir|.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NAX; k++) begin
        plo_r[k] <= q_i[QLO_W-1:0] * md[k];
        phi_r[k] <= q_i[QW-1:QLO_W] * md[k];
      end
      sgn_a_r  <= {NAX{tneg_i}} ^ {dir_i[2][CW-1], dir_i[1][CW-1], dir_i[0][CW-1]};
      org_a_r  <= org_i;
      q_a_r    <= q_i;
      tneg_a_r <= tneg_i;
      tpos_a_r <= !tneg_i && (q_i != '0);
      skip_a_r <= skip_i;
    end
  end

  // Stage B: drop the t fraction and cap the product magnitude at 2^40.
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      sum[k]   = MW'({phi_r[k][HI_SH-1:0], {HI_UP{1'b0}}}) + MW'(plo_r[k][PL_W-1:T_FRAC]);
      m_nxt[k] = ((|phi_r[k][PH_W-1:HI_SH]) || (sum[k] > CAP)) ? CAP : sum[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NAX; k++) begin
        m_r[k] <= m_nxt[k];
      end
      sgn_b_r  <= sgn_a_r;
      org_b_r  <= org_a_r;
      q_b_r    <= q_a_r;
      tneg_b_r <= tneg_a_r;
      tpos_b_r <= tpos_a_r;
      skip_b_r <= skip_a_r;
    end
  end

  // Stage C: point coordinates and the box test with tolerance.
  always_comb begin
    ok = 1'b1;
    for (int k = 0; k < NAX; k++) begin
      v[k] = VW'(org_b_r[k]) + (sgn_b_r[k] ? -$signed({{(VW-MW){1'b0}}, m_r[k]})
                                             :  $signed({{(VW-MW){1'b0}}, m_r[k]}));
      if (k != AX) begin
        if (v[k] < VW'(box_lo_i[k]) - EPS || v[k] > VW'(box_hi_i[k]) + EPS) begin
          ok = 1'b0;
        end
      end
    end
    cand_nxt.f = !skip_b_r && (!ray_only_i || tpos_b_r) && ok;
    cand_nxt.t = tneg_b_r ? -$signed({1'b0, q_b_r}) : $signed({1'b0, q_b_r});
    for (int k = 0; k < NAX; k++) begin
      cand_nxt.v[k] = v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_o = cand_r;

endmodule

/* sv/rbi_sel.sv */
// Registered tree that keeps the passing face with the smallest t.
module rbi_sel (
  input  logic           clk,
  input  logic           en,
  input  rbi_pkg::cand_t cand_i [rbi_pkg::NFACE],
  output rbi_pkg::cand_t cand_o
);
  import rbi_pkg::*;

  cand_t s1_r [3];
  cand_t s2a_r, s2b_r;
  cand_t s3_r;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    if (a.f && (!b.f || ($signed(a.t) <= $signed(b.t)))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= pick(cand_i[2*i], cand_i[2*i+1]);
      end
      s2a_r <= pick(s1_r[0], s1_r[1]);
      s2b_r <= s1_r[2];
      s3_r  <= pick(s2a_r, s2b_r);
    end
  end

  assign cand_o = s3_r;

endmodule

/* sv/ray_box_intersect_top.sv */
// Top level of the fixed-point ray / line against axis-aligned box test.
//
//  channel  direction  handshake               payload
//  in       slave      in_tvalid / in_tready   in_tdata: origin xyz, dir xyz
//  out      master     out_tvalid / out_tready out_tdata: hit, point xyz
//  cfg      slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken per cycle while the output is not stalled; results leave in request order.
// The 61-stage bit-per-stage dividers that form t make up most of the pipeline.
// Reset clears the box registers, ray mode and all valid bits.
// A stalled output freezes the whole pipeline; in_tready follows the output.
`include "ray_box_intersect_top_defines.svh"

module ray_box_intersect_top #(
  parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [rbi_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // hit, hit_x, hit_y, hit_z (1 + 3 x 32 bits), zero pad to 104 bits
  output logic [rbi_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rbi_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rbi_pkg::CW-1:0]     cfg_data
);
  import rbi_pkg::*;

  localparam int LAT = 1 + DIV_LAT + FACE_LAT + SEL_LAT;
  localparam logic [CW-1:0] EPS =
    CW'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

  typedef struct packed {
    logic [NAX-1:0]   skip;
    logic [NFACE-1:0] tneg;
    coord_t [NAX-1:0] org;
    coord_t [NAX-1:0] dir;
  } side_t;

  logic             adv;
  coord_t [NAX-1:0] box_lo_r, box_hi_r;
  logic             ray_only_r;
  coord_t [NAX-1:0] org_w, dir_w;
  logic [NUM_W-1:0] num_w   [NFACE];
  logic [NUM_W-1:0] nmag_w  [NFACE];
  logic [NUM_W-1:0] nmag_r  [NFACE];
  logic [DEN_W-1:0] dmag_w  [NAX];
  logic [DEN_W-1:0] dmag_r  [NAX];
  side_t            side_nxt;
  side_t            side_r;
  side_t            dly_r   [DIV_LAT];
  logic [QW-1:0]    q_w     [NFACE];
  cand_t            cand_w  [NFACE];
  cand_t            best_w;
  logic [LAT-1:0]   vld_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r   <= '0;
      box_hi_r   <= '0;
      ray_only_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_X:    box_lo_r[0] <= cfg_data;
        REG_MIN_Y:    box_lo_r[1] <= cfg_data;
        REG_MIN_Z:    box_lo_r[2] <= cfg_data;
        REG_MAX_X:    box_hi_r[0] <= cfg_data;
        REG_MAX_Y:    box_hi_r[1] <= cfg_data;
        REG_MAX_Z:    box_hi_r[2] <= cfg_data;
        REG_RAY_ONLY: ray_only_r  <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Entry stage: face distances, direction magnitudes, skip flags.
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      org_w[a]  = in_tdata[a*CW +: CW];
      dir_w[a]  = in_tdata[(NAX+a)*CW +: CW];
      dmag_w[a] = dir_w[a][CW-1] ? (DEN_W'(0) - DEN_W'(dir_w[a])) : DEN_W'(dir_w[a]);
      side_nxt.skip[a] = (dmag_w[a] <= EPS) || (dmag_w[a] == '0);
    end
    for (int f = 0; f < NFACE; f++) begin
      num_w[f] = (f % 2 == 1) ? NUM_W'(box_lo_r[f/2]) - NUM_W'(org_w[f/2])
                              : NUM_W'(box_hi_r[f/2]) - NUM_W'(org_w[f/2]);
      nmag_w[f] = num_w[f][NUM_W-1] ? (NUM_W'(0) - num_w[f]) : num_w[f];
      side_nxt.tneg[f] = num_w[f][NUM_W-1] ^ dir_w[f/2][CW-1];
    end
    side_nxt.org = org_w;
    side_nxt.dir = dir_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int f = 0; f < NFACE; f++) begin
        nmag_r[f] <= nmag_w[f];
      end
      for (int a = 0; a < NAX; a++) begin
        dmag_r[a] <= dmag_w[a];
      end
      side_r   <= side_nxt;
      dly_r[0] <= side_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  for (genvar f = 0; f < NFACE; f++) begin : g_face
    rbi_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (nmag_r[f]),
      .den_i (dmag_r[f/2]),
      .q_o   (q_w[f])
    );

    rbi_face #(
      .FRAC_BITS (FRAC_BITS),
      .AX        (f / 2)
    ) u_face (
      .clk        (clk),
      .en         (adv),
      .ray_only_i (ray_only_r),
      .box_lo_i   (box_lo_r),
      .box_hi_i   (box_hi_r),
      .org_i      (dly_r[DIV_LAT-1].org),
      .dir_i      (dly_r[DIV_LAT-1].dir),
      .q_i        (q_w[f]),
      .tneg_i     (dly_r[DIV_LAT-1].tneg[f]),
      .skip_i     (dly_r[DIV_LAT-1].skip[f/2]),
      .cand_o     (cand_w[f])
    );
  end

  rbi_sel u_sel (
    .clk    (clk),
    .en     (adv),
    .cand_i (cand_w),
    .cand_o (best_w)
  );

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0] = best_w.f;
    if (best_w.f) begin
      for (int a = 0; a < NAX; a++) begin
        out_data_nxt[1 + a*CW +: CW] = sat32(best_w.v[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `RBI_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[OUT_USED-1:1] == '0, "miss result carries a nonzero point")
  `RBI_ASSERT_NXT(a_accept_enters, in_tvalid && in_tready, vld_r[0], "accepted request did not enter the pipeline")
  `RBI_ASSERT_NXT(a_stall_freeze, !in_tready, $stable(vld_r) && out_tvalid, "pipeline moved during an output stall")
  `RBI_ASSERT_NXT(a_cfg_ray, cfg_valid && cfg_ready && cfg_index == REG_RAY_ONLY, ray_only_r == $past(cfg_data[0]), "ray mode write lost")

endmodule

/* dv/ray_box_intersect_checker.sv */
// Checker that predicts and compares every ray box intersection result.
`timescale 1ns / 100ps

module ray_box_intersect_checker
  import rbi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_W-1:0]    out_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CW-1:0]       cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  hit_count,
  output int                  result_count
);

  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
    coord_t z;
  } hit_point_t;

  localparam longint CAP = 64'sd1 << CAP_BITS;

  longint box_lo [3];
  longint box_hi [3];
  logic   ray_mode;
  hit_point_t expected_hits[$];

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Scales t (T_FRAC fraction bits) by a direction component, capped in magnitude.
  function automatic longint scale_by_t(input longint t, input longint d);
    logic [127:0] p;
    longint       m;
    p = 128'(magnitude(t)) * 128'(magnitude(d));
    p = p >> T_FRAC;
    m = (p > 128'(CAP)) ? CAP : longint'(p[63:0]);
    return ((t < 0) != (d < 0)) ? -m : m;
  endfunction

  function automatic coord_t clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic hit_point_t predict_hit(input logic [IN_W-1:0] req);
    longint     o [3];
    longint     d [3];
    longint     best, t, bound, v;
    logic [63:0] q;
    bit         found, ok, neg;
    int         ax, k;
    hit_point_t r;
    for (int a = 0; a < 3; a++) begin
      o[a] = longint'(coord_t'(req[a*CW +: CW]));
      d[a] = longint'(coord_t'(req[(3+a)*CW +: CW]));
    end
    found = 0;
    best = 0;
    for (int face = 0; face < NFACE; face++) begin
      ax = face >> 1;
      bound = face[0] ? box_lo[ax] : box_hi[ax];
      // Epsilon is zero LSBs at 16 fraction bits, so only a zero direction skips.
      if (d[ax] == 0) continue;
      q = (64'(magnitude(bound - o[ax])) << T_FRAC) / 64'(magnitude(d[ax]));
      neg = ((bound - o[ax]) < 0) != (d[ax] < 0);
      t = neg ? -longint'(q) : longint'(q);
      if (ray_mode && t <= 0) continue;
      ok = 1;
      for (int j = 1; j < 3; j++) begin
        k = (ax + j) % 3;
        v = o[k] + scale_by_t(t, d[k]);
        if (v < box_lo[k] || v > box_hi[k]) ok = 0;
      end
      if (ok) begin
        if (!found || t < best) best = t;
        found = 1;
      end
    end
    r.hit = found;
    r.x = found ? clamp32(o[0] + scale_by_t(best, d[0])) : '0;
    r.y = found ? clamp32(o[1] + scale_by_t(best, d[1])) : '0;
    r.z = found ? clamp32(o[2] + scale_by_t(best, d[2])) : '0;
    return r;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_point_t exp_r, got;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = 0;
        box_hi[a] = 0;
      end
      ray_mode = 0;
      fail_count = 0;
      hit_count = 0;
      result_count = 0;
      expected_hits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_X:    box_lo[0] = longint'(coord_t'(cfg_data));
          REG_MIN_Y:    box_lo[1] = longint'(coord_t'(cfg_data));
          REG_MIN_Z:    box_lo[2] = longint'(coord_t'(cfg_data));
          REG_MAX_X:    box_hi[0] = longint'(coord_t'(cfg_data));
          REG_MAX_Y:    box_hi[1] = longint'(coord_t'(cfg_data));
          REG_MAX_Z:    box_hi[2] = longint'(coord_t'(cfg_data));
          REG_RAY_ONLY: ray_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.x = out_tdata[1 +: CW];
        got.y = out_tdata[1 + CW +: CW];
        got.z = out_tdata[1 + 2*CW +: CW];
        result_count++;
        if (expected_hits.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected result %h", out_tdata);
        end else begin
          exp_r = expected_hits.pop_front();
          if (got.hit) hit_count++;
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result %0d expected hit=%b (%h %h %h) got hit=%b (%h %h %h)",
                       result_count, exp_r.hit, exp_r.x, exp_r.y, exp_r.z,
                       got.hit, got.x, got.y, got.z);
          end
        end
      end
      if (in_tvalid && in_tready) expected_hits.push_back(predict_hit(in_tdata));
    end
  end

endmodule

/* dv/ray_box_intersect_top_tb.sv */
// Stimulus and verdict for the ray box intersection regression.
`timescale 1ns / 100ps

module ray_box_intersect_top_tb;
  import rbi_pkg::*;

  localparam int ONE = 32'h10000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CW-1:0]     cfg_data = '0;

  int fail_count, pending, hit_count, result_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_taken = 0;
  int hold_cycles = 0;
  int sent = 0;
  int box_lo [3];
  int box_hi [3];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ray_box_intersect_top u_dut (.*);

  ray_box_intersect_checker u_chk (.*);

  // A new hold length from the stimulus starts a long receiver stall counted here.
  always @(posedge clk) begin
    if (hold_len != hold_taken) begin
      hold_taken <= hold_len;
      hold_cycles <= hold_len;
      out_tready <= 0;
    end else if (hold_cycles > 0) begin
      out_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_ray(input int ox, oy, oz, dx, dy, dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {dz, dy, dx, oz, oy, ox};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Registers are only written once every outstanding request has drained.
  task automatic set_box(input int lx, ly, lz, hx, hy, hz, input bit ray);
    logic [CW-1:0] vals [7];
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    vals = '{lx, ly, lz, hx, hy, hz, {31'd0, ray}};
    box_lo = '{lx, ly, lz};
    box_hi = '{hx, hy, hz};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1;
      cfg_index <= IDX_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
  endtask

  task automatic directed_rays();
    send_ray(-5*ONE, 0, 0, ONE, 0, 0);
    send_ray(5*ONE, ONE/2, -ONE/2, -ONE, 0, 0);
    send_ray(0, -7*ONE, 0, 0, ONE, 0);
    send_ray(0, 0, 9*ONE, 0, 0, -2*ONE);
    send_ray(0, 0, 0, ONE, ONE, ONE);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(-5*ONE, ONE, ONE, ONE, 0, 0);
    send_ray(-5*ONE, 2*ONE, 0, ONE, 0, 0);
    send_ray(-5*ONE, ONE, ONE + 1, ONE, 0, 0);
    send_ray(ONE - 1, 0, 0, 32'h7fffffff, 0, 0);
    send_ray(5*ONE, 0, 0, ONE, 0, 0);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send_ray(-5*ONE, 0, 0, 1, 32'h7fffffff, 32'h80000000);
    send_ray(-5*ONE, 0, 0, ONE, -1, 1);
    send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_ray(-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE);
    send_ray(0, 0, 0, 0, 0, -ONE);
  endtask

  task automatic random_rays(input int n);
    int o [3];
    int d [3];
    int sel, tgt, s;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
        if (sel < 60) begin
          // Aim through a point near the box so that faces are really crossed.
          tgt = box_lo[a] + int'($urandom_range(box_hi[a] - box_lo[a] + 0));
          if (box_hi[a] < box_lo[a] || box_hi[a] - box_lo[a] < 0) tgt = box_lo[a];
          o[a] = tgt + $signed($urandom_range(1 << 22)) - (1 << 21);
          s = $urandom_range(3);
          d[a] = (tgt - o[a]) >>> s;
          if ($urandom_range(9) == 0) d[a] = 0;
        end else if (sel < 80) begin
          o[a] = $urandom;
          d[a] = $urandom;
        end else begin
          o[a] = $signed($urandom_range(1 << 24)) - (1 << 23);
          d[a] = $urandom_range(3) == 0 ? 0 : $signed($urandom_range(1 << 18)) - (1 << 17);
        end
      end
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end
  endtask

  task automatic random_box(input bit ray);
    int lo [3];
    for (int a = 0; a < 3; a++) lo[a] = $signed($urandom_range(1 << 23)) - (1 << 22);
    set_box(lo[0], lo[1], lo[2], lo[0] + $urandom_range(1 << 22),
            lo[1] + $urandom_range(1 << 22), lo[2] + $urandom_range(1 << 22), ray);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0);
    directed_rays();
    random_rays(250);

    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1);
    send_idle_pct = 74;
    directed_rays();
    random_rays(200);

    random_box(1);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    hold_len = 400;
    random_rays(280);

    set_box(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_rays(200);

    // Inverted box: min above max on every axis.
    set_box(ONE, 2*ONE, ONE, -ONE, ONE, 0, 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_rays(150);

    set_box(0, 0, 0, 0, 0, 0, 1);
    send_idle_pct = 74;
    random_rays(150);

    random_box(0);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_rays(350);

    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests over seven box settings, line and ray mode, with idling.",
             sent);
    $display("Checked %0d results, %0d of them hits.", result_count, hit_count);
    if (fail_count == 0) begin
      $display("ray_box_intersect_top regression: pass");
    end else begin
      $display("ray_box_intersect_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("ray_box_intersect_top regression: fail");
    $finish;
  end

endmodule
